>>> design/nc_pkg.sv
`timescale 1ns / 1ps

package nc_pkg;

   // Fixed field widths of the streams and the configuration register.
   localparam int WEIGHT_W   = 18;
   localparam int VERTEX_W   = 6;
   localparam int CFG_W      = 7;

   // A matrix entry with this weight stands for a missing edge.
   localparam logic signed [WEIGHT_W-1:0] NO_EDGE = 18'sd100000;

   // Starting distance of every vertex except the source.
   localparam int FAR_DISTANCE = 1000000000;

endpackage

>>> design/negative_cycle_finder_top.sv
`timescale 1ns / 1ps

// Negative cycle finder.
// The req_ stream carries the edge weight matrix, one entry per transfer, in row-major
// order; a weight of 100000 marks a missing edge. Entries are taken one per cycle while
// the block is idle. The csr_ port sets the vertex count (0 acts as 1, values above
// MAX_VERTICES act as MAX_VERTICES) and restarts loading at the first entry.
// After the last entry the block sets the source distance to 0, every other distance to
// FAR_DISTANCE and every predecessor to invalid, then runs Bellman-Ford from vertex 0:
// n relaxation passes plus one detection pass. Each row reads its source distance, then
// steps through the row's edges, then drains; the distance memory has one read port.
// A detected cycle starts a predecessor walk and then a trace before results appear.
// The rsp_ stream then carries the cycle's vertices in order, the final one with tlast,
// or a single transfer with cycle_found 0 and vertex 0 when there is no negative cycle.
// A stalled receiver simply holds the output register and the sequencer waits. A new
// matrix can be loaded while the final result still waits to be taken. Synchronous reset
// returns the sequencer to idle, empties the output register and sets the vertex count to
// the lesser of MAX_VERTICES and 64; memory contents are not cleared.

module negative_cycle_finder_top
   import nc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // [17:0] weight, [23:18] zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [0] cycle_found, [6:1] vertex, [7] zero
   output logic                rsp_tlast,   // last
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data  // vertex_count
);

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = 2 * VW;
   localparam int DW = (3 * VW + 20 > 32) ? 3 * VW + 20 : 32;
   localparam logic [DW-1:0] FAR_D = DW'(FAR_DISTANCE);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_INIT    = 13'b0000000000010,
      ST_ROW     = 13'b0000000000100,
      ST_ROW_LAT = 13'b0000000001000,
      ST_EDGE    = 13'b0000000010000,
      ST_DRAIN   = 13'b0000000100000,
      ST_WK_RD   = 13'b0000001000000,
      ST_WK_DAT  = 13'b0000010000000,
      ST_TR_RD   = 13'b0000100000000,
      ST_TR_DAT  = 13'b0001000000000,
      ST_EM_RD   = 13'b0010000000000,
      ST_EM_LD   = 13'b0100000000000,
      ST_NONE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]   count_ff, count_in;
   logic [2*CW-1:0] load_ff, load_in;
   logic [2*CW-1:0] entries;
   logic [CW-1:0]   count_m1;
   logic [VW-1:0]   last_idx;

   logic [VW-1:0]   a_ff, a_in, b_ff, b_in, b_s1_ff, b_s1_in;
   logic            s1_valid_ff, s1_valid_in;
   logic [AW-1:0]   row_base_ff, row_base_in;
   logic [CW-1:0]   pass_ff, pass_in;
   logic signed [DW-1:0] da_ff, da_in;
   logic [VW-1:0]   cur_ff, cur_in, tgt_ff, tgt_in, idx_ff, idx_in;
   logic [CW-1:0]   step_ff, step_in;

   logic            out_valid_ff, out_valid_in, out_found_ff, out_found_in;
   logic            out_last_ff, out_last_in;
   logic [VERTEX_W-1:0] out_vertex_ff, out_vertex_in;

   // Memory ports.
   logic                wt_we;
   logic [AW-1:0]       wt_waddr, wt_raddr;
   logic [WEIGHT_W-1:0] wt_rdata;
   logic                dist_we;
   logic [VW-1:0]       dist_waddr, dist_raddr;
   logic [DW-1:0]       dist_wdata, dist_rdata;
   logic                pred_we;
   logic [VW-1:0]       pred_waddr;
   logic [VW:0]         pred_wdata, pred_rdata;
   logic                cyc_we;
   logic [VW-1:0]       cyc_waddr, cyc_wdata, cyc_rdata;

   logic                 improve;
   logic signed [DW-1:0] new_dist;
   logic                 detect, hit, out_free, req_fire;
   logic [VW+VERTEX_W-1:0] vertex_ext;
   logic [2*CW-1:0]      load_next;

   assign entries  = count_ff * count_ff;
   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[VW-1:0];
   assign detect   = (pass_ff == count_ff);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;
   assign hit      = s1_valid_ff && improve && detect;
   assign load_next = load_ff + (2*CW)'(1);
   assign vertex_ext = {{VERTEX_W{1'b0}}, cyc_rdata};

   nc_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (req_tdata[WEIGHT_W-1:0]),
      .rd_addr (wt_raddr),
      .rd_data (wt_rdata)
   );

   nc_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   // Predecessor entries carry a valid flag in the top bit.
   nc_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_waddr),
      .wr_data (pred_wdata),
      .rd_addr (cur_ff),
      .rd_data (pred_rdata)
   );

   // The cycle is stored in trace order (backward along edges) and read out in reverse.
   nc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_cycle_ram (
      .clock   (clock),
      .wr_en   (cyc_we),
      .wr_addr (cyc_waddr),
      .wr_data (cyc_wdata),
      .rd_addr (idx_ff),
      .rd_data (cyc_rdata)
   );

   nc_relax #(.DW(DW)) u_relax (
      .dist_from (da_ff),
      .dist_to   (signed'(dist_rdata)),
      .weight    (signed'(wt_rdata)),
      .improve   (improve),
      .new_dist  (new_dist)
   );

   assign wt_we    = req_fire;
   assign wt_waddr = load_ff[AW-1:0];
   assign wt_raddr = row_base_ff + AW'(b_ff);
   assign dist_raddr = (state_ff == ST_ROW) ? a_ff : b_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      load_in      = load_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      b_s1_in      = b_s1_ff;
      s1_valid_in  = 1'b0;
      row_base_in  = row_base_ff;
      pass_in      = pass_ff;
      da_in        = da_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_found_in = out_found_ff;
      out_vertex_in = out_vertex_ff;
      out_last_in  = out_last_ff;
      dist_we      = 1'b0;
      dist_waddr   = b_s1_ff;
      dist_wdata   = new_dist;
      pred_we      = 1'b0;
      pred_waddr   = b_s1_ff;
      pred_wdata   = {1'b1, a_ff};
      cyc_we       = 1'b0;
      cyc_waddr    = step_ff[VW-1:0];
      cyc_wdata    = pred_rdata[VW-1:0];

      // Relaxation of the edge whose weight and target distance arrived this cycle.
      if (s1_valid_ff && improve && !detect) begin
         dist_we = 1'b1;
         pred_we = 1'b1;
         if (b_s1_ff == a_ff) begin
            da_in = new_dist;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (load_next == entries) begin
                  load_in  = '0;
                  idx_in   = '0;
                  state_in = ST_INIT;
               end else begin
                  load_in = load_next;
               end
            end
         end
         ST_INIT: begin
            dist_we    = 1'b1;
            dist_waddr = idx_ff;
            dist_wdata = (idx_ff == '0) ? '0 : FAR_D;
            pred_we    = 1'b1;
            pred_waddr = idx_ff;
            pred_wdata = '0;
            if (idx_ff == last_idx) begin
               a_in        = '0;
               pass_in     = '0;
               row_base_in = '0;
               state_in    = ST_ROW;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end
         ST_ROW: begin
            state_in = ST_ROW_LAT;
         end
         ST_ROW_LAT: begin
            da_in    = dist_rdata;
            b_in     = '0;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            s1_valid_in = 1'b1;
            b_s1_in     = b_ff;
            if (b_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               b_in = b_ff + VW'(1);
            end
         end
         ST_DRAIN: begin
            if (a_ff == last_idx) begin
               if (detect) begin
                  state_in = ST_NONE;
               end else begin
                  pass_in     = pass_ff + CW'(1);
                  a_in        = '0;
                  row_base_in = '0;
                  state_in    = ST_ROW;
               end
            end else begin
               a_in        = a_ff + VW'(1);
               row_base_in = row_base_ff + AW'(count_ff);
               state_in    = ST_ROW;
            end
         end
         ST_WK_RD: begin
            state_in = ST_WK_DAT;
         end
         ST_WK_DAT: begin
            if (!pred_rdata[VW]) begin
               state_in = ST_NONE;
            end else begin
               cur_in = pred_rdata[VW-1:0];
               if (step_ff == count_m1) begin
                  tgt_in   = pred_rdata[VW-1:0];
                  step_in  = '0;
                  state_in = ST_TR_RD;
               end else begin
                  step_in  = step_ff + CW'(1);
                  state_in = ST_WK_RD;
               end
            end
         end
         ST_TR_RD: begin
            state_in = ST_TR_DAT;
         end
         ST_TR_DAT: begin
            if (!pred_rdata[VW] || step_ff == count_ff) begin
               state_in = ST_NONE;
            end else begin
               cyc_we  = 1'b1;
               step_in = step_ff + CW'(1);
               cur_in  = pred_rdata[VW-1:0];
               if (pred_rdata[VW-1:0] == tgt_ff) begin
                  idx_in   = step_ff[VW-1:0];
                  state_in = ST_EM_RD;
               end else begin
                  state_in = ST_TR_RD;
               end
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_found_in  = 1'b1;
               out_vertex_in = vertex_ext[VERTEX_W-1:0];
               out_last_in   = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - VW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         ST_NONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_found_in  = 1'b0;
               out_vertex_in = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The first edge that can still be relaxed in the detection pass starts the walk.
      if (hit) begin
         cur_in      = b_s1_ff;
         step_in     = '0;
         s1_valid_in = 1'b0;
         state_in    = ST_WK_RD;
      end

      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            count_in = CW'(1);
         end else if (32'(csr_wr_data) > MAX_VERTICES) begin
            count_in = CW'(MAX_VERTICES);
         end else begin
            count_in = CW'(csr_wr_data);
         end
         load_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CW'(MAX_VERTICES < 64 ? MAX_VERTICES : 64);
         load_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         load_ff      <= load_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      b_s1_ff       <= b_s1_in;
      row_base_ff   <= row_base_in;
      pass_ff       <= pass_in;
      da_ff         <= da_in;
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      out_found_ff  <= out_found_in;
      out_vertex_ff <= out_vertex_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_vertex_ff, out_found_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> design/nc_ram.sv
`timescale 1ns / 1ps

module nc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/nc_relax.sv
`timescale 1ns / 1ps

module nc_relax
   import nc_pkg::*;
#(
   parameter int DW = 38
) (
   input  logic signed [DW-1:0]       dist_from,
   input  logic signed [DW-1:0]       dist_to,
   input  logic signed [WEIGHT_W-1:0] weight,
   output logic                       improve,
   output logic signed [DW-1:0]       new_dist
);

   logic signed [DW-1:0] weight_ext;

   // Sign-extend the edge weight to the distance width before the add.
   assign weight_ext = {{(DW-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
   assign new_dist   = dist_from + weight_ext;
   assign improve    = (weight != NO_EDGE) && (dist_to > new_dist);

endmodule

>>> design/nc_checker.sv
`timescale 1ns / 1ps

module nc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A result left waiting must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // The no-cycle answer is a single, final transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tlast && rsp_tdata[6:1] == 6'd0)
      else $error("no-cycle result malformed");

   // Loading cannot start while a cycle is still being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during cycle output");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind negative_cycle_finder_top nc_checker u_nc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
